[rtl/hds_pkg.sv]
// ----------------------------------------------------------------------------
// hds_pkg
// Shared types and constants for the hemisphere direction sampler.
// ----------------------------------------------------------------------------
`default_nettype none

package hds_pkg;

  localparam int MAX_TRIES = 64;
  localparam int FRAC_BITS = 14;

  localparam int QW    = FRAC_BITS + 1;        // quotient width, q <= 2^FRAC_BITS
  localparam int NUMW  = 32 + FRAC_BITS + 1;   // (m << FRAC_BITS) + (len >> 1)
  localparam int TRY_W = $clog2(MAX_TRIES + 1);

  localparam logic [31:0] LCG_A_RESET = 32'd1151752134;
  localparam logic [31:0] LCG_B_RESET = 32'd2070363486;
  localparam logic [31:0] LCG_A_MUL   = 32'd1701532575;
  localparam logic [31:0] LCG_A_ADD   = 32'd571550083;
  localparam logic [31:0] LCG_B_MUL   = 32'd3145804233;
  localparam logic [31:0] LCG_B_ADD   = 32'd4178903934;
  localparam int          MIX_SHIFT   = 16;
  localparam logic [31:0] HALF_RANGE  = 32'h8000_0000;
  localparam logic [63:0] ONE_Q62     = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
  } in_t;

  typedef struct packed {
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic               flipped;
    logic               gave_up;
  } out_t;

  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [63:0] rad;
    logic [31:0] mag;
    logic [31:0] len;
  } iter_req_t;

  typedef struct packed {
    logic          done;
    logic [31:0]   root;
    logic [QW-1:0] quot;
  } iter_rsp_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DRAW,
    ST_SQ,
    ST_ACC,
    ST_CHECK,
    ST_SQRT,
    ST_DIVGO,
    ST_DIV,
    ST_DOTM,
    ST_DOTA,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

[rtl/hds_lcg.sv]
// ----------------------------------------------------------------------------
// hds_lcg
// Two 32-bit linear congruential generators mixed by shift and xor.
// ----------------------------------------------------------------------------
`default_nettype none

module hds_lcg (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        step,
  output logic      [31:0] draw
);

  logic [31:0] a_r, a_nxt;
  logic [31:0] b_r, b_nxt;

  assign a_nxt = a_r * hds_pkg::LCG_A_MUL + hds_pkg::LCG_A_ADD;
  assign b_nxt = b_r * hds_pkg::LCG_B_MUL + hds_pkg::LCG_B_ADD;
  // draw is taken from the advanced generators
  assign draw  = (a_nxt << hds_pkg::MIX_SHIFT) ^ b_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_r <= hds_pkg::LCG_A_RESET;
      b_r <= hds_pkg::LCG_B_RESET;
    end else if (step) begin
      a_r <= a_nxt;
      b_r <= b_nxt;
    end
  end

endmodule

`default_nettype wire

[rtl/hds_iter.sv]
// ----------------------------------------------------------------------------
// hds_iter
// Shared compare-subtract unit: bit-serial integer square root (one result
// bit per cycle) and restoring division (one quotient bit per cycle).
// ----------------------------------------------------------------------------
`default_nettype none

module hds_iter (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire hds_pkg::iter_req_t req,
  output hds_pkg::iter_rsp_t      rsp
);

  logic                      busy_r;
  logic                      done_r;
  logic                      div_r;
  logic [4:0]                cnt_r;
  logic [63:0]               acc_r;
  logic [63:0]               res_r;
  logic [63:0]               bit_r;
  logic [hds_pkg::QW-1:0]    low_r;
  logic [31:0]               len_r;

  logic [hds_pkg::NUMW-1:0]  num;
  logic [63:0]               sub_a;
  logic [63:0]               sub_b;
  logic [63:0]               diff;
  logic                      ge;

  assign num   = hds_pkg::NUMW'({req.mag, hds_pkg::FRAC_BITS'(0)})
               + hds_pkg::NUMW'(req.len >> 1);
  assign sub_a = div_r ? {acc_r[62:0], low_r[hds_pkg::QW-1]} : acc_r;
  assign sub_b = div_r ? 64'(len_r) : res_r + bit_r;
  assign diff  = sub_a - sub_b;
  assign ge    = sub_a >= sub_b;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= busy_r && (cnt_r == 5'd0);
      if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == 5'd0) begin
        busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      div_r <= req.is_div;
      res_r <= '0;
      len_r <= req.len;
      if (req.is_div) begin
        // high part is below len since the quotient fits QW bits
        acc_r <= 64'(num[hds_pkg::NUMW-1:hds_pkg::QW]);
        low_r <= num[hds_pkg::QW-1:0];
        cnt_r <= 5'(hds_pkg::FRAC_BITS);
      end else begin
        acc_r <= req.rad;
        bit_r <= 64'h4000_0000_0000_0000;
        cnt_r <= 5'd31;
      end
    end else if (busy_r) begin
      cnt_r <= cnt_r - 5'd1;
      if (div_r) begin
        acc_r <= ge ? diff : sub_a;
        res_r <= {res_r[62:0], ge};
        low_r <= low_r << 1;
      end else begin
        if (ge) begin
          acc_r <= diff;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
    end
  end

  assign rsp.done = done_r;
  assign rsp.root = res_r[31:0];
  assign rsp.quot = res_r[hds_pkg::QW-1:0];

endmodule

`default_nettype wire

[rtl/hemisphere_direction_sampler.sv]
// ----------------------------------------------------------------------------
// hemisphere_direction_sampler
// Random unit direction in the hemisphere of a surface normal.
// ----------------------------------------------------------------------------
// One normal is taken at a time; in_stall stays high until its result has been
// moved into the output register, which can hold a finished word while the
// next normal is accepted. Each rejection attempt takes three draws, each one
// generator step, one square on the shared multiplier and one add, then the
// length check. An accepted attempt adds a square root and three divisions,
// both on the one shared compare-subtract unit, then the dot product on the
// shared multiplier, a finishing state and the return to idle to accept the
// next normal. When MAX_TRIES attempts all fail the normal is echoed with
// gave_up set.
// ----------------------------------------------------------------------------
`default_nettype none

module hemisphere_direction_sampler (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire hds_pkg::in_t  in_data,
  output logic               out_valid,
  input  wire logic          out_stall,
  output hds_pkg::out_t      out_data
);

  hds_pkg::state_t              state_r, state_nxt;
  logic [1:0]                   k_r;
  logic [hds_pkg::TRY_W-1:0]    tries_r;
  hds_pkg::in_t                 n_r;
  logic signed [31:0]           p_r [3];
  logic [hds_pkg::QW-1:0]       q_r [3];
  logic [63:0]                  d2_r;
  logic signed [63:0]           dot_r;
  logic signed [63:0]           prod_r;
  logic [31:0]                  len_r;
  logic                         gave_r;
  hds_pkg::out_t                out_r;
  logic                         out_valid_r;

  logic                         lcg_step;
  logic [31:0]                  draw;
  hds_pkg::iter_req_t           req;
  hds_pkg::iter_rsp_t           rsp;
  logic signed [31:0]           mul_a;
  logic signed [31:0]           mul_b;
  logic signed [63:0]           mul_p;
  logic signed [31:0]           n_sel;
  logic [31:0]                  mag;
  logic                         hit;
  logic                         last_try;
  logic                         flip;
  logic                         out_free;
  hds_pkg::out_t                res;

  hds_lcg u_lcg (
    .clk  (clk),
    .rst_n(rst_n),
    .step (lcg_step),
    .draw (draw)
  );

  hds_iter u_iter (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .rsp  (rsp)
  );

  always_comb begin
    case (k_r)
      2'd0:    n_sel = 32'(n_r.normal_x);
      2'd1:    n_sel = 32'(n_r.normal_y);
      default: n_sel = 32'(n_r.normal_z);
    endcase
  end

  assign mul_a    = p_r[k_r];
  assign mul_b    = (state_r == hds_pkg::ST_DOTM) ? n_sel : p_r[k_r];
  assign mul_p    = 64'(mul_a) * 64'(mul_b);
  assign mag      = p_r[k_r][31] ? 32'(-p_r[k_r]) : 32'(p_r[k_r]);
  assign hit      = (d2_r != 64'd0) && (d2_r <= hds_pkg::ONE_Q62);
  assign last_try = tries_r == hds_pkg::TRY_W'(hds_pkg::MAX_TRIES - 1);
  assign flip     = dot_r[63];
  assign out_free = !out_valid_r || !out_stall;
  assign lcg_step = state_r == hds_pkg::ST_DRAW;

  always_comb begin
    req.start  = 1'b0;
    req.is_div = 1'b0;
    req.rad    = d2_r;
    req.mag    = mag;
    req.len    = len_r;
    if (state_r == hds_pkg::ST_CHECK && hit) begin
      req.start = 1'b1;
    end else if (state_r == hds_pkg::ST_DIVGO) begin
      req.start  = 1'b1;
      req.is_div = 1'b1;
    end
  end

  // final word: sign of the raw component, then the hemisphere flip
  always_comb begin
    logic [31:0] v [3];
    for (int i = 0; i < 3; i++) begin
      v[i] = (p_r[i][31] ^ flip) ? -32'(q_r[i]) : 32'(q_r[i]);
    end
    if (gave_r) begin
      res.dir_x   = n_r.normal_x;
      res.dir_y   = n_r.normal_y;
      res.dir_z   = n_r.normal_z;
      res.flipped = 1'b0;
      res.gave_up = 1'b1;
    end else begin
      res.dir_x   = v[0][15:0];
      res.dir_y   = v[1][15:0];
      res.dir_z   = v[2][15:0];
      res.flipped = flip;
      res.gave_up = 1'b0;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      hds_pkg::ST_IDLE:  if (in_valid) state_nxt = hds_pkg::ST_DRAW;
      hds_pkg::ST_DRAW:  state_nxt = hds_pkg::ST_SQ;
      hds_pkg::ST_SQ:    state_nxt = hds_pkg::ST_ACC;
      hds_pkg::ST_ACC:   state_nxt = (k_r == 2'd2) ? hds_pkg::ST_CHECK : hds_pkg::ST_DRAW;
      hds_pkg::ST_CHECK: begin
        if (hit) begin
          state_nxt = hds_pkg::ST_SQRT;
        end else if (last_try) begin
          state_nxt = hds_pkg::ST_FIN;
        end else begin
          state_nxt = hds_pkg::ST_DRAW;
        end
      end
      hds_pkg::ST_SQRT:  if (rsp.done) state_nxt = hds_pkg::ST_DIVGO;
      hds_pkg::ST_DIVGO: state_nxt = hds_pkg::ST_DIV;
      hds_pkg::ST_DIV: begin
        if (rsp.done) begin
          state_nxt = (k_r == 2'd2) ? hds_pkg::ST_DOTM : hds_pkg::ST_DIVGO;
        end
      end
      hds_pkg::ST_DOTM:  state_nxt = hds_pkg::ST_DOTA;
      hds_pkg::ST_DOTA:  state_nxt = (k_r == 2'd2) ? hds_pkg::ST_FIN : hds_pkg::ST_DOTM;
      hds_pkg::ST_FIN:   if (out_free) state_nxt = hds_pkg::ST_IDLE;
      default:           state_nxt = hds_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= hds_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == hds_pkg::ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      hds_pkg::ST_IDLE: begin
        n_r     <= in_data;
        k_r     <= 2'd0;
        tries_r <= '0;
        d2_r    <= '0;
        gave_r  <= 1'b0;
      end
      hds_pkg::ST_DRAW: p_r[k_r] <= signed'(draw ^ hds_pkg::HALF_RANGE);
      hds_pkg::ST_SQ:   prod_r   <= mul_p;
      hds_pkg::ST_ACC: begin
        d2_r <= d2_r + 64'(prod_r);
        if (k_r != 2'd2) k_r <= k_r + 2'd1;
      end
      hds_pkg::ST_CHECK: begin
        tries_r <= tries_r + 1'b1;
        k_r     <= 2'd0;
        d2_r    <= '0;
        dot_r   <= '0;
        gave_r  <= !hit && last_try;
      end
      hds_pkg::ST_SQRT: begin
        if (rsp.done) len_r <= (rsp.root == 32'd0) ? 32'd1 : rsp.root;
      end
      hds_pkg::ST_DIV: begin
        if (rsp.done) begin
          q_r[k_r] <= (rsp.quot > hds_pkg::QW'(1 << hds_pkg::FRAC_BITS))
                    ? hds_pkg::QW'(1 << hds_pkg::FRAC_BITS) : rsp.quot;
          k_r      <= (k_r == 2'd2) ? 2'd0 : k_r + 2'd1;
        end
      end
      hds_pkg::ST_DOTM: prod_r <= mul_p;
      hds_pkg::ST_DOTA: begin
        dot_r <= dot_r + prod_r;
        if (k_r != 2'd2) k_r <= k_r + 2'd1;
      end
      hds_pkg::ST_FIN: begin
        if (out_free) out_r <= res;
      end
      default: ;
    endcase
  end

  assign in_stall  = state_r != hds_pkg::ST_IDLE;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_accept_starts_draw : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> state_r == hds_pkg::ST_DRAW)
    else $error("accepted word did not start drawing");

  a_tries_bounded : assert property (@(posedge clk) disable iff (!rst_n)
    tries_r <= hds_pkg::TRY_W'(hds_pkg::MAX_TRIES))
    else $error("attempt counter beyond limit");

  a_gave_not_flipped : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_r.flipped && out_r.gave_up))
    else $error("give-up word marked as flipped");

  a_sqrt_only_on_hit : assert property (@(posedge clk) disable iff (!rst_n)
    state_r == hds_pkg::ST_SQRT && $past(state_r) == hds_pkg::ST_CHECK
      |-> $past(d2_r) != 64'd0)
    else $error("square root started on zero length");

endmodule

`default_nettype wire
